// File: hw/rtl/circ_pkg.sv
// Shared widths, types and request structure for the circle outline point generator.
`timescale 1ns / 1ps
`default_nettype none
package circ_pkg;

	localparam int RADIUS_BITS = 10;
	localparam int COORD_BITS  = 12;
	localparam int OUT_BITS    = COORD_BITS + 2;
	localparam int SUM_BITS    = (OUT_BITS > RADIUS_BITS + 1) ? OUT_BITS : RADIUS_BITS + 1;
	localparam int CNT_BITS    = $clog2(RADIUS_BITS + 1);
	localparam int IN_BITS     = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
	localparam int OUT_DBITS   = ((2 * OUT_BITS + 7) / 8) * 8;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic [RADIUS_BITS-1:0]     rad_t;
	typedef logic [RADIUS_BITS:0]       stepx_t;
	typedef logic [2*RADIUS_BITS-1:0]   rsq_t;
	typedef logic [2*RADIUS_BITS:0]     xsq_t;
	typedef logic [OUT_BITS-1:0]        point_t;
	typedef logic [SUM_BITS-1:0]        sum_t;
	typedef logic [CNT_BITS-1:0]        cnt_t;
	typedef logic [RADIUS_BITS+1:0]     rem_t;
	typedef logic [RADIUS_BITS+3:0]     remx_t;
	typedef logic [IN_BITS-1:0]         in_data_t;
	typedef logic [OUT_DBITS-1:0]       out_data_t;

	typedef struct packed {
		logic   done;
		coord_t cx;
		coord_t cy;
		stepx_t x;
		rad_t   y;
	} emit_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/circ_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module circ_sqrt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire circ_pkg::rsq_t    radicand,
	output logic                   busy,
	output logic                   fin,
	output circ_pkg::rad_t         root
);

	circ_pkg::rsq_t  rad_q;
	circ_pkg::rem_t  rem_q;
	circ_pkg::rad_t  root_q;
	circ_pkg::cnt_t  cnt_q;
	circ_pkg::remx_t rem_x;
	circ_pkg::remx_t trial;
	circ_pkg::remx_t diff;
	logic            ge;

	always_comb begin
		rem_x = {rem_q, rad_q[2*circ_pkg::RADIUS_BITS-1 -: 2]};
		trial = circ_pkg::remx_t'({root_q, 2'b01});
		ge    = rem_x >= trial;
		diff  = rem_x - trial;
		root  = {root_q[circ_pkg::RADIUS_BITS-2:0], ge};
		busy  = cnt_q != '0;
		fin   = cnt_q == circ_pkg::cnt_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= circ_pkg::cnt_t'(circ_pkg::RADIUS_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - circ_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q  <= {rad_q[2*circ_pkg::RADIUS_BITS-3:0], 2'b00};
			rem_q  <= ge ? circ_pkg::rem_t'(diff) : circ_pkg::rem_t'(rem_x);
			root_q <= root;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/circ_emit.sv
// Sequencer: eight mirrored points or a done result into the output register.
`timescale 1ns / 1ps
`default_nettype none
module circ_emit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire circ_pkg::emit_req_t   req,
	output logic                       busy,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output circ_pkg::out_data_t        m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);

	circ_pkg::emit_req_t req_q;
	logic                pend_q;
	logic [2:0]          idx_q;
	logic                ov_q;
	circ_pkg::point_t    px_q;
	circ_pkg::point_t    py_q;
	logic                last_q;
	logic                done_q;
	logic                load;
	circ_pkg::sum_t      off_x;
	circ_pkg::sum_t      off_y;
	circ_pkg::sum_t      sum_x;
	circ_pkg::sum_t      sum_y;

	always_comb begin
		load  = pend_q && (!ov_q || m_tready);
		off_x = idx_q[2] ? circ_pkg::sum_t'(req_q.y) : circ_pkg::sum_t'(req_q.x);
		off_y = idx_q[2] ? circ_pkg::sum_t'(req_q.x) : circ_pkg::sum_t'(req_q.y);
		sum_x = idx_q[0] ? circ_pkg::sum_t'(req_q.cx) - off_x
				: circ_pkg::sum_t'(req_q.cx) + off_x;
		sum_y = idx_q[1] ? circ_pkg::sum_t'(req_q.cy) - off_y
				: circ_pkg::sum_t'(req_q.cy) + off_y;
		busy  = pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (req_valid) begin
				pend_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				idx_q <= idx_q + 3'd1;
				if (req_q.done || idx_q == 3'd7) begin
					pend_q <= 1'b0;
				end
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			req_q <= req;
		end
		if (load) begin
			px_q   <= req_q.done ? '0 : sum_x[circ_pkg::OUT_BITS-1:0];
			py_q   <= req_q.done ? '0 : sum_y[circ_pkg::OUT_BITS-1:0];
			last_q <= !req_q.done && idx_q == 3'd7;
			done_q <= req_q.done;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = circ_pkg::out_data_t'({py_q, px_q});
	assign m_tlast  = last_q;
	assign m_tuser  = done_q;

endmodule
`default_nettype wire

// File: hw/rtl/circle_outline_point_generator.sv
// Top level of the circle outline point generator.
//
//  group | dir | tdata (low bit up)               | tlast        | tuser
//  s_*   | in  | center_x, center_y, radius, pad  | -            | op (0 start, 1 advance)
//  m_*   | out | point_x, point_y, pad            | last_of_step | circle_done
//
// A start loads the circle registers. A point-producing advance starts circ_sqrt, which
// forms one root digit per cycle over RADIUS_BITS digits; unless the output stalls, the
// eight points leave one per cycle alongside the root. A done advance gives a done result.
// Reset clears all control state and leaves no circle active.
// Input is held while a root is in progress or the point sequencer still holds a step;
// a stalled output holds its register and holds off the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module circle_outline_point_generator (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire circ_pkg::in_data_t    s_tdata,   // center_x, center_y, radius
	input  wire logic                  s_tuser,   // op
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output circ_pkg::out_data_t        m_tdata,   // point_x, point_y
	output logic                       m_tlast,
	output logic                       m_tuser    // circle_done
);

	circ_pkg::coord_t    cx_q;
	circ_pkg::coord_t    cy_q;
	circ_pkg::stepx_t    step_x_q;
	circ_pkg::rad_t      step_y_q;
	circ_pkg::rsq_t      rsq_q;
	circ_pkg::xsq_t      xsq_q;
	logic                active_q;
	circ_pkg::xsq_t      xsq_nxt;
	circ_pkg::xsq_t      rsq_ext;
	circ_pkg::rsq_t      radicand;
	circ_pkg::rad_t      in_radius;
	circ_pkg::emit_req_t req;
	logic                acc;
	logic                start_acc;
	logic                adv_acc;
	logic                adv_done;
	logic                sq_start;
	logic                sq_busy;
	logic                sq_fin;
	circ_pkg::rad_t      sq_root;
	logic                em_busy;

	always_comb begin
		acc       = s_tvalid && s_tready;
		start_acc = acc && (s_tuser == circ_pkg::OP_START);
		adv_acc   = acc && (s_tuser == circ_pkg::OP_ADVANCE);
		in_radius = s_tdata[2*circ_pkg::COORD_BITS +: circ_pkg::RADIUS_BITS];
		adv_done  = !active_q || (step_x_q > circ_pkg::stepx_t'(step_y_q));
		xsq_nxt   = xsq_q + circ_pkg::xsq_t'({step_x_q, 1'b1});
		rsq_ext   = circ_pkg::xsq_t'(rsq_q);
		radicand  = (xsq_nxt >= rsq_ext) ? '0 : circ_pkg::rsq_t'(rsq_ext - xsq_nxt);
		sq_start  = adv_acc && !adv_done;
		req.done  = adv_done;
		req.cx    = cx_q;
		req.cy    = cy_q;
		req.x     = step_x_q;
		req.y     = step_y_q;
	end

	assign s_tready = !sq_busy && !em_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_x_q <= '0;
			step_y_q <= '0;
			rsq_q    <= '0;
			xsq_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
		end else begin
			if (start_acc) begin
				cx_q     <= s_tdata[0 +: circ_pkg::COORD_BITS];
				cy_q     <= s_tdata[circ_pkg::COORD_BITS +: circ_pkg::COORD_BITS];
				step_x_q <= '0;
				step_y_q <= in_radius;
				rsq_q    <= circ_pkg::rsq_t'(in_radius) * circ_pkg::rsq_t'(in_radius);
				xsq_q    <= '0;
				active_q <= 1'b1;
			end else if (sq_start) begin
				step_x_q <= step_x_q + circ_pkg::stepx_t'(1);
				xsq_q    <= xsq_nxt;
			end
			if (sq_fin) begin
				step_y_q <= sq_root;
			end
		end
	end

	circ_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.busy     (sq_busy),
		.fin      (sq_fin),
		.root     (sq_root)
	);

	circ_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (adv_acc),
		.req       (req),
		.busy      (em_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

// File: hw/rtl/circ_check.sv
// Port-level checker for the circle outline point generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module circ_check (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire circ_pkg::in_data_t  s_tdata,
	input wire logic                s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire circ_pkg::out_data_t m_tdata,
	input wire logic                m_tlast,
	input wire logic                m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output transfer changed while stalled");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
		else $error("done result carries point data");

	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == circ_pkg::OP_START) |=> !$rose(m_tvalid))
		else $error("start produced a result");

	a_adv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == circ_pkg::OP_ADVANCE) |=> !s_tready)
		else $error("advance accepted without holding off input");

endmodule

bind circle_outline_point_generator circ_check u_check (.*);
`default_nettype wire

// File: tb/tb_circle_outline_point_generator.sv
// Self-checking testbench for the circle outline point generator: stream driver, monitor, predictor.
`timescale 1ns / 1ps
module tb_circle_outline_point_generator;

	localparam int LIMIT = 60000;

	typedef struct {
		bit               op;
		circ_pkg::coord_t cx;
		circ_pkg::coord_t cy;
		circ_pkg::rad_t   radius;
	} circle_cmd_t;

	typedef struct packed {
		circ_pkg::point_t px;
		circ_pkg::point_t py;
		logic             last;
		logic             done;
	} plot_point_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	circ_pkg::in_data_t  s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	circ_pkg::out_data_t m_tdata;
	logic                m_tlast;
	logic                m_tuser;

	circle_cmd_t pending_cmds[$];
	plot_point_t expected_points[$];
	circle_cmd_t next_cmd;
	int          cycle = 0;
	int          hold_left;
	int          errors = 0;
	int          n_cmds = 0;
	int          n_points = 0;
	int          n_done = 0;
	bit          calm;

	// predictor state
	circ_pkg::stepx_t pr_x;
	circ_pkg::rad_t   pr_y;
	circ_pkg::rsq_t   pr_rsq;
	circ_pkg::coord_t pr_cx;
	circ_pkg::coord_t pr_cy;
	bit               pr_active;

	circle_outline_point_generator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic circ_pkg::rad_t floor_root(input circ_pkg::rsq_t v);
		circ_pkg::rad_t res;
		circ_pkg::rad_t trial;
		circ_pkg::xsq_t sq;
		res = '0;
		for (int b = circ_pkg::RADIUS_BITS - 1; b >= 0; b--) begin
			trial = res | (circ_pkg::rad_t'(1) << b);
			sq = trial * trial;
			if (sq <= v)
				res = trial;
		end
		return res;
	endfunction

	function automatic circ_pkg::point_t offset(input circ_pkg::coord_t c,
			input circ_pkg::stepx_t d, input bit neg);
		return neg ? circ_pkg::point_t'(c) - circ_pkg::point_t'(d)
			: circ_pkg::point_t'(c) + circ_pkg::point_t'(d);
	endfunction

	task automatic push_point(input circ_pkg::point_t px, input circ_pkg::point_t py,
			input logic last);
		plot_point_t p;
		p.px = px;
		p.py = py;
		p.last = last;
		p.done = 1'b0;
		expected_points.insert(expected_points.size(), p);
	endtask

	task automatic predict_step(input bit op, input circ_pkg::coord_t cx,
			input circ_pkg::coord_t cy, input circ_pkg::rad_t radius);
		plot_point_t      p;
		circ_pkg::xsq_t   xsq;
		circ_pkg::stepx_t y;
		if (op == circ_pkg::OP_START) begin
			pr_cx = cx;
			pr_cy = cy;
			pr_x = '0;
			pr_y = radius;
			pr_rsq = radius * radius;
			pr_active = 1'b1;
		end else if (!pr_active || pr_x > circ_pkg::stepx_t'(pr_y)) begin
			p = '0;
			p.done = 1'b1;
			expected_points.insert(expected_points.size(), p);
		end else begin
			y = circ_pkg::stepx_t'(pr_y);
			push_point(offset(pr_cx, pr_x, 0), offset(pr_cy, y, 0), 1'b0);
			push_point(offset(pr_cx, pr_x, 1), offset(pr_cy, y, 0), 1'b0);
			push_point(offset(pr_cx, pr_x, 0), offset(pr_cy, y, 1), 1'b0);
			push_point(offset(pr_cx, pr_x, 1), offset(pr_cy, y, 1), 1'b0);
			push_point(offset(pr_cx, y, 0), offset(pr_cy, pr_x, 0), 1'b0);
			push_point(offset(pr_cx, y, 1), offset(pr_cy, pr_x, 0), 1'b0);
			push_point(offset(pr_cx, y, 0), offset(pr_cy, pr_x, 1), 1'b0);
			push_point(offset(pr_cx, y, 1), offset(pr_cy, pr_x, 1), 1'b1);
			pr_x = pr_x + 1'b1;
			xsq = pr_x * pr_x;
			pr_y = (xsq >= circ_pkg::xsq_t'(pr_rsq)) ? '0
				: floor_root(circ_pkg::rsq_t'(circ_pkg::xsq_t'(pr_rsq) - xsq));
		end
	endtask

	task automatic add_start(input circ_pkg::coord_t cx, input circ_pkg::coord_t cy,
			input circ_pkg::rad_t radius);
		circle_cmd_t c;
		c.op = circ_pkg::OP_START;
		c.cx = cx;
		c.cy = cy;
		c.radius = radius;
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// center and radius are don't-care on an advance; keep them random
	task automatic add_advance(input int count);
		circle_cmd_t c;
		for (int i = 0; i < count; i++) begin
			c.op = circ_pkg::OP_ADVANCE;
			c.cx = circ_pkg::coord_t'($urandom);
			c.cy = circ_pkg::coord_t'($urandom);
			c.radius = circ_pkg::rad_t'($urandom);
			pending_cmds.insert(pending_cmds.size(), c);
		end
	endtask

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d results outstanding", $time, cycle,
				expected_points.size());
			$display("status: fail");
			$finish;
		end
	end

	always_comb calm = (cycle >= 1200 && cycle < 1800);

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
				next_cmd = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= circ_pkg::in_data_t'({next_cmd.radius, next_cmd.cy, next_cmd.cx});
				s_tuser <= next_cmd.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long sink hold-off while the source keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (cycle == 600) begin
			hold_left <= 300;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= (hold_left <= 1) && (calm || $urandom_range(99) >= 8);
		end
	end

	// check results first, then predict from the accepted command
	always @(posedge clk) begin
		plot_point_t got;
		plot_point_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.px = m_tdata[circ_pkg::OUT_BITS-1:0];
				got.py = m_tdata[2*circ_pkg::OUT_BITS-1:circ_pkg::OUT_BITS];
				got.last = m_tlast;
				got.done = m_tuser;
				if (expected_points.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, got x=%0d y=%0d l=%b d=%b",
						$time, $signed(got.px), $signed(got.py), got.last, got.done);
				end else begin
					want = expected_points.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t mismatch: exp x=%0d y=%0d l=%b d=%b, got x=%0d y=%0d l=%b d=%b",
							$time, $signed(want.px), $signed(want.py), want.last, want.done,
							$signed(got.px), $signed(got.py), got.last, got.done);
					end
				end
				if (got.done)
					n_done++;
				else
					n_points++;
			end
			if (s_tvalid && s_tready) begin
				n_cmds++;
				predict_step(s_tuser, s_tdata[circ_pkg::COORD_BITS-1:0],
					s_tdata[2*circ_pkg::COORD_BITS-1:circ_pkg::COORD_BITS],
					s_tdata[2*circ_pkg::COORD_BITS +: circ_pkg::RADIUS_BITS]);
			end
		end
	end

	initial begin
		int total;
		int r;
		int steps;
		int advances;
		pr_x = '0;
		pr_y = '0;
		pr_rsq = '0;
		pr_cx = '0;
		pr_cy = '0;
		pr_active = 1'b0;
		arst_n = 1'b0;

		// advance with no circle loaded
		add_advance(1);
		// zero radius: eight points at the center, then done twice
		add_start(12'd0, 12'd0, 10'd0);
		add_advance(3);
		// largest center and radius
		add_start(12'd4095, 12'd4095, 10'd1023);
		add_advance(2);
		// smallest center, largest radius: negative coordinates
		add_start(12'd0, 12'd0, 10'd1023);
		add_advance(2);
		// abandon a circle mid-way, then run the new one to completion
		add_start(12'd2730, 12'd1365, 10'd5);
		add_advance(1);
		add_start(12'd1365, 12'd2730, 10'd3);
		add_advance(5);
		add_start(12'd100, 12'd4000, 10'd1);
		add_advance(3);
		total = pending_cmds.size();

		while (total < 114) begin
			if ($urandom_range(99) < 85) begin
				r = ($urandom_range(9) < 8) ? $urandom_range(12) : $urandom_range(1023);
				add_start(circ_pkg::coord_t'($urandom), circ_pkg::coord_t'($urandom),
					circ_pkg::rad_t'(r));
				steps = (r * 7) / 10 + 1;
				if (r > 12)
					advances = $urandom_range(1, 3);
				else if ($urandom_range(99) < 15)
					advances = $urandom_range(steps);
				else
					advances = steps + $urandom_range(2);
				add_advance(advances);
				total += advances + 1;
			end else begin
				advances = $urandom_range(1, 2);
				add_advance(advances);
				total += advances;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d commands, %0d plotted points and %0d done results,",
			n_cmds, n_points, n_done);
		$display("including zero and full radius, edge centers, abandoned circles and stalls.");
		if (errors == 0 && expected_points.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
